FILE: src/cbm_pkg.sv
package cbm_pkg;

  localparam int MAX_PRG_BANKS = 16;
  localparam int MAX_CHR_BANKS = 64;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int ACT_W    = 2;
  localparam int REGION_W = 3;
  localparam int LOCAL_W  = 17;
  localparam int PCNT_W   = 5;
  localparam int CCNT_W   = 7;
  localparam int MODE_W   = 3;
  localparam int PRG_W    = 4;
  localparam int CHR_W    = 6;
  localparam int SEL_W    = 3;
  localparam int NT_W     = 12;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam int MOD_STEPS = CHR_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  typedef enum logic [REGION_W-1:0] {
    REGION_CPU_RAM  = 3'd0,
    REGION_PPU_REGS = 3'd1,
    REGION_IO_REGS  = 3'd2,
    REGION_OPEN_BUS = 3'd3,
    REGION_PRG_ROM  = 3'd4,
    REGION_CHR_ROM  = 3'd5,
    REGION_NAMETAB  = 3'd6,
    REGION_NONE     = 3'd7
  } region_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_CPU_RD = 2'd0,
    ACT_CPU_WR = 2'd1,
    ACT_PPU_RD = 2'd2,
    ACT_PPU_WR = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_WRAP,
    S_BOOT,
    S_DONE
  } state_e;

  localparam logic [MODE_W-1:0] MIR_VERT    = 3'd0;
  localparam logic [MODE_W-1:0] MIR_HORIZ   = 3'd1;
  localparam logic [MODE_W-1:0] MIR_FOUR    = 3'd2;
  localparam logic [MODE_W-1:0] MIR_SCR_A   = 3'd3;
  localparam logic [MODE_W-1:0] MIR_SCR_B   = 3'd4;

  localparam logic [1:0] REG_PRG_CNT = 2'd0;
  localparam logic [1:0] REG_CHR_CNT = 2'd1;
  localparam logic [1:0] REG_MIRROR  = 2'd2;

  localparam logic [SEL_W-1:0] BSEL_CHR2K_0 = 3'd0;
  localparam logic [SEL_W-1:0] BSEL_CHR2K_1 = 3'd1;
  localparam logic [SEL_W-1:0] BSEL_PRG_0   = 3'd6;
  localparam logic [SEL_W-1:0] BSEL_PRG_1   = 3'd7;

  typedef struct packed {
    logic              start;
    logic [CHR_W-1:0]  dividend;
    logic [CCNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CHR_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [NT_W-1:0] mirror_addr(input logic [MODE_W-1:0] mode,
                                                  input logic [NT_W-1:0] a);
    logic [NT_W-1:0] r;
    unique case (mode)
      MIR_VERT:  r = {1'b0, a[10:0]};
      MIR_FOUR:  r = a;
      MIR_SCR_A: r = {2'b00, a[9:0]};
      MIR_SCR_B: r = {2'b01, a[9:0]};
      default:   r = {1'b0, a[11], a[9:0]};
    endcase
    return r;
  endfunction

endpackage

FILE: src/cbm_mod_unit.sv
module cbm_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbm_pkg::mod_req_t req_i,
  output cbm_pkg::mod_rsp_t rsp_o
);
  import cbm_pkg::*;

  localparam logic [MOD_CNT_W-1:0] LastStep = MOD_CNT_W'(MOD_STEPS - 1);

  logic                 busy_q;
  logic [MOD_CNT_W-1:0] cnt_q;
  logic [CHR_W-1:0]     r_q, r_d;
  logic [CHR_W-1:0]     dvd_q;
  logic [CCNT_W-1:0]    dvs_q;
  logic [CHR_W:0]       trial;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    trial = {r_q, dvd_q[CHR_W-1]};
    if (trial >= dvs_q) begin
      r_d = CHR_W'(trial - dvs_q);
    end else begin
      r_d = trial[CHR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q   <= '0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      r_q   <= r_d;
      dvd_q <= {dvd_q[CHR_W-2:0], 1'b0};
    end
  end

  assign rsp_o.done = busy_q && (cnt_q == LastStep);
  assign rsp_o.rem  = r_d;

endmodule

FILE: src/cartridge_bank_mapper.sv
// an item runs through decode and done to a registered result; the input stalls
// until idle. Odd bank register writes use the shared remainder unit, one bank
// number bit per cycle; a 2 KB chr pair then writes its second slot in S_WRAP.
// writing a bank count register reloads the chr banks in S_BOOT, stall held
// reset: async active low, counts 16/64, horizontal mirroring, chr banks 0..7,
// prg banks 0 and 1, bank select 0
module cartridge_bank_mapper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cbm_pkg::ACT_W-1:0]      action_i,
  input  logic [cbm_pkg::ADDR_W-1:0]     bus_address_i,
  input  logic [cbm_pkg::DATA_W-1:0]     bus_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cbm_pkg::REGION_W-1:0]   region_o,
  output logic [cbm_pkg::LOCAL_W-1:0]    local_address_o,
  output logic                           write_strobe_o,
  output logic [cbm_pkg::DATA_W-1:0]     pass_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbm_pkg::PADDR_W-1:0]    paddr,
  input  logic [cbm_pkg::PDATA_W-1:0]    pwdata,
  output logic [cbm_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import cbm_pkg::*;

  state_e state_q, state_d;

  logic [PCNT_W-1:0] prg_cnt_q;
  logic [CCNT_W-1:0] chr_cnt_q;
  logic [MODE_W-1:0] mode_q;
  logic [PCNT_W-1:0] pc_cnt;
  logic [CCNT_W-1:0] cc_cnt;

  logic [SEL_W-1:0]  bank_sel_q;
  logic              bsel_we;
  logic [CHR_W-1:0]  chr_q [8];
  logic [PRG_W-1:0]  prg_q [2];
  logic              chr_we, prg_we;
  logic [2:0]        chr_idx;
  logic              prg_idx;
  logic [CHR_W-1:0]  chr_wdata;
  logic [PRG_W-1:0]  prg_wdata;

  logic [ACT_W-1:0]  act_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] data_q;
  logic [CHR_W-1:0]  run_q, run_d;
  logic [2:0]        boot_idx_q, boot_idx_d;

  logic              cfg_wr, cnt_wr, in_acc, out_load;
  logic [CHR_W:0]    wrap_sum;
  logic [CHR_W-1:0]  wrap_val, boot_val;
  logic              is_bank_wr;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  region_e             res_region;
  logic [LOCAL_W-1:0]  res_local;
  logic                res_strobe;
  logic [PRG_W-1:0]    prg_bank;
  logic [PCNT_W-1:0]   fixed_bank;
  logic [13:0]         pa;

  logic                out_valid_q;
  logic [REGION_W-1:0] region_q;
  logic [LOCAL_W-1:0]  local_q;
  logic                strobe_q;
  logic [DATA_W-1:0]   pass_q;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cnt_wr = cfg_wr && (paddr[3:2] == REG_PRG_CNT || paddr[3:2] == REG_CHR_CNT);

  always_comb begin
    unique case (paddr[3:2])
      REG_PRG_CNT: prdata = PDATA_W'(prg_cnt_q);
      REG_CHR_CNT: prdata = PDATA_W'(chr_cnt_q);
      REG_MIRROR:  prdata = PDATA_W'(mode_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q <= PCNT_W'(MAX_PRG_BANKS);
      chr_cnt_q <= CCNT_W'(MAX_CHR_BANKS);
      mode_q    <= MIR_HORIZ;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PRG_CNT: prg_cnt_q <= pwdata[PCNT_W-1:0];
        REG_CHR_CNT: chr_cnt_q <= pwdata[CCNT_W-1:0];
        REG_MIRROR:  mode_q    <= pwdata[MODE_W-1:0];
        default:     ;
      endcase
    end
  end

  // saturated bank counts
  always_comb begin
    if (prg_cnt_q < PCNT_W'(2)) begin
      pc_cnt = PCNT_W'(2);
    end else if (prg_cnt_q > PCNT_W'(MAX_PRG_BANKS)) begin
      pc_cnt = PCNT_W'(MAX_PRG_BANKS);
    end else begin
      pc_cnt = prg_cnt_q;
    end
    if (chr_cnt_q == '0) begin
      cc_cnt = CCNT_W'(1);
    end else if (chr_cnt_q > CCNT_W'(MAX_CHR_BANKS)) begin
      cc_cnt = CCNT_W'(MAX_CHR_BANKS);
    end else begin
      cc_cnt = chr_cnt_q;
    end
  end

  // next bank number, wrapping at the chr count
  assign wrap_sum = {1'b0, run_q} + 1'b1;
  assign wrap_val = (CCNT_W'(wrap_sum) == cc_cnt) ? '0 : wrap_sum[CHR_W-1:0];
  assign boot_val = (boot_idx_q == '0) ? '0 : wrap_val;

  assign in_stall_o = (state_q != S_IDLE) || cnt_wr;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_bank_wr = (act_q == ACT_CPU_WR) && (addr_q[15:13] == 3'b100);

  cbm_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_comb begin
    mod_req.start = (state_q == S_DECODE) && is_bank_wr && addr_q[0];
    case (bank_sel_q) inside
      BSEL_CHR2K_0, BSEL_CHR2K_1: begin
        mod_req.dividend = {data_q[5:1], 1'b0};
        mod_req.divisor  = cc_cnt;
      end
      BSEL_PRG_0, BSEL_PRG_1: begin
        mod_req.dividend = CHR_W'(data_q[3:0]);
        mod_req.divisor  = CCNT_W'(pc_cnt);
      end
      default: begin
        mod_req.dividend = data_q[5:0];
        mod_req.divisor  = cc_cnt;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    run_d      = run_q;
    boot_idx_d = boot_idx_q;
    bsel_we    = 1'b0;
    chr_we     = 1'b0;
    chr_idx    = '0;
    chr_wdata  = '0;
    prg_we     = 1'b0;
    prg_idx    = 1'b0;
    prg_wdata  = '0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cnt_wr) begin
          state_d    = S_BOOT;
          boot_idx_d = '0;
        end else if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (is_bank_wr && addr_q[0]) begin
          state_d = S_DIV;
        end else begin
          bsel_we = is_bank_wr;
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (mod_rsp.done) begin
          case (bank_sel_q) inside
            BSEL_CHR2K_0: begin
              chr_we    = 1'b1;
              chr_idx   = 3'd0;
              chr_wdata = mod_rsp.rem;
              run_d     = mod_rsp.rem;
              state_d   = S_WRAP;
            end
            BSEL_CHR2K_1: begin
              chr_we    = 1'b1;
              chr_idx   = 3'd2;
              chr_wdata = mod_rsp.rem;
              run_d     = mod_rsp.rem;
              state_d   = S_WRAP;
            end
            BSEL_PRG_0, BSEL_PRG_1: begin
              prg_we    = 1'b1;
              prg_idx   = bank_sel_q[0];
              prg_wdata = mod_rsp.rem[PRG_W-1:0];
              state_d   = S_DONE;
            end
            default: begin
              chr_we    = 1'b1;
              chr_idx   = bank_sel_q + 3'd2;
              chr_wdata = mod_rsp.rem;
              state_d   = S_DONE;
            end
          endcase
        end
      end
      S_WRAP: begin
        chr_we    = 1'b1;
        chr_idx   = (bank_sel_q == BSEL_CHR2K_0) ? 3'd1 : 3'd3;
        chr_wdata = wrap_val;
        state_d   = S_DONE;
      end
      S_BOOT: begin
        chr_we     = 1'b1;
        chr_idx    = boot_idx_q;
        chr_wdata  = boot_val;
        run_d      = boot_val;
        boot_idx_d = boot_idx_q + 1'b1;
        if (boot_idx_q == 3'd7) begin
          state_d = S_IDLE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      boot_idx_q  <= '0;
      bank_sel_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      boot_idx_q <= boot_idx_d;
      if (bsel_we) begin
        bank_sel_q <= data_q[SEL_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // bank number registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) begin
        chr_q[k] <= CHR_W'(k);
      end
      prg_q[0] <= PRG_W'(0);
      prg_q[1] <= PRG_W'(1);
    end else begin
      if (chr_we) begin
        chr_q[chr_idx] <= chr_wdata;
      end
      if (cnt_wr) begin
        prg_q[0] <= PRG_W'(0);
        prg_q[1] <= PRG_W'(1);
      end else if (prg_we) begin
        prg_q[prg_idx] <= prg_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= action_i;
      addr_q <= bus_address_i;
      data_q <= bus_data_i;
    end
    run_q <= run_d;
    if (out_load) begin
      region_q <= res_region;
      local_q  <= res_local;
      strobe_q <= res_strobe;
      pass_q   <= data_q;
    end
  end

  // address decode
  assign pa         = addr_q[13:0];
  assign fixed_bank = pc_cnt - PCNT_W'(2) + PCNT_W'(addr_q[13]);
  assign prg_bank   = addr_q[14] ? fixed_bank[PRG_W-1:0] : prg_q[addr_q[13]];

  always_comb begin
    res_region = REGION_NONE;
    res_local  = '0;
    res_strobe = 1'b0;
    if (!act_q[1]) begin
      if (addr_q < 16'h2000) begin
        res_region = REGION_CPU_RAM;
        res_local  = LOCAL_W'(addr_q[10:0]);
        res_strobe = act_q[0];
      end else if (addr_q < 16'h4000) begin
        res_region = REGION_PPU_REGS;
        res_local  = LOCAL_W'(addr_q[2:0]);
        res_strobe = act_q[0];
      end else if (addr_q < 16'h4020) begin
        res_region = REGION_IO_REGS;
        res_local  = LOCAL_W'(addr_q[4:0]);
        res_strobe = act_q[0];
      end else if (!act_q[0]) begin
        if (!addr_q[15]) begin
          res_region = REGION_OPEN_BUS;
        end else begin
          res_region = REGION_PRG_ROM;
          res_local  = {prg_bank, addr_q[12:0]};
        end
      end
    end else begin
      if (!pa[13]) begin
        if (!act_q[0]) begin
          res_region = REGION_CHR_ROM;
          res_local  = {1'b0, chr_q[pa[12:10]], pa[9:0]};
        end
      end else begin
        res_region = REGION_NAMETAB;
        res_local  = LOCAL_W'(mirror_addr(mode_q, pa[11:0]));
        res_strobe = act_q[0];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign region_o        = region_q;
  assign local_address_o = local_q;
  assign write_strobe_o  = strobe_q;
  assign pass_data_o     = pass_q;

  logic [7:0] chr_ok;
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      chr_ok[k] = CCNT_W'(chr_q[k]) < cc_cnt;
    end
  end

  a_chr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (&chr_ok))
    else $error("chr bank number not below chr count");

  a_prg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PCNT_W'(prg_q[0]) < pc_cnt) && (PCNT_W'(prg_q[1]) < pc_cnt))
    else $error("prg bank number not below prg count");

  a_mod_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == S_DIV))
    else $error("remainder unit finished outside divide state");

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_DECODE))
    else $error("accepted item not decoded");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending item");

endmodule

FILE: test/tb_top.sv
module tb_top;
  import cbm_pkg::*;

  typedef struct {
    action_e     act;
    logic [15:0] addr;
    logic [7:0]  data;
  } bus_item_t;

  typedef struct {
    region_e     region;
    logic [16:0] local_addr;
    logic        strobe;
    logic [7:0]  data;
  } bus_map_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall_o;
  logic [ACT_W-1:0]    act_r = '0;
  logic [ADDR_W-1:0]   addr_r = '0;
  logic [DATA_W-1:0]   data_r = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  logic [REGION_W-1:0] region_o;
  logic [LOCAL_W-1:0]  local_address_o;
  logic                write_strobe_o;
  logic [DATA_W-1:0]   pass_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // mapper state as the block should hold it
  int          prg_cnt_reg;
  int          chr_cnt_reg;
  logic [2:0]  mirror_reg;
  logic [2:0]  bank_sel;
  logic [6:0]  chr_bank [8];
  logic [3:0]  prg_bank [2];

  bus_item_t bus_items [$];
  bus_map_t  expected_maps [$];
  bus_item_t nxt;
  bus_map_t  got;
  int        sent_total = 0;
  int        done_total = 0;
  int        mismatches = 0;
  int        in_gap = 0;
  int        stall_left = 0;
  bit        item_taken = 1'b0;
  bit        calm = 1'b0;
  int        calm_left = 0;

  cartridge_bank_mapper i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .action_i        (act_r),
    .bus_address_i   (addr_r),
    .bus_data_i      (data_r),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .region_o        (region_o),
    .local_address_o (local_address_o),
    .write_strobe_o  (write_strobe_o),
    .pass_data_o     (pass_data_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int prg_span();
    int c;
    c = prg_cnt_reg;
    if (c < 2) c = 2;
    if (c > MAX_PRG_BANKS) c = MAX_PRG_BANKS;
    return c;
  endfunction

  function automatic int chr_span();
    int c;
    c = chr_cnt_reg;
    if (c < 1) c = 1;
    if (c > MAX_CHR_BANKS) c = MAX_CHR_BANKS;
    return c;
  endfunction

  function automatic void set_chr_pair(int slot, int bank);
    int first;
    first = bank % chr_span();
    chr_bank[slot] = 7'(first);
    chr_bank[slot + 1] = 7'((first + 1) % chr_span());
  endfunction

  function automatic void reload_banks();
    prg_bank[0] = 4'(0 % prg_span());
    prg_bank[1] = 4'(1 % prg_span());
    set_chr_pair(0, 0);
    set_chr_pair(2, 2);
    for (int i = 4; i < 8; i++) chr_bank[i] = 7'(i % chr_span());
  endfunction

  function automatic bus_map_t map_access(action_e act, logic [15:0] addr, logic [7:0] data);
    bus_map_t m;
    int       a;
    int       pa;
    int       slot;
    int       bank;
    bit       wr;
    a = addr;
    pa = a & 'h3FFF;
    m.region = REGION_NONE;
    m.local_addr = '0;
    m.strobe = 1'b0;
    m.data = data;
    if (act == ACT_CPU_RD || act == ACT_CPU_WR) begin
      wr = (act == ACT_CPU_WR);
      if (a < 'h2000) begin
        m.region = REGION_CPU_RAM; m.local_addr = 17'(a & 'h7FF); m.strobe = wr;
      end else if (a < 'h4000) begin
        m.region = REGION_PPU_REGS; m.local_addr = 17'(a & 7); m.strobe = wr;
      end else if (a < 'h4020) begin
        m.region = REGION_IO_REGS; m.local_addr = 17'(a & 'h1F); m.strobe = wr;
      end else if (!wr) begin
        if (a < 'h8000) begin
          m.region = REGION_OPEN_BUS;
        end else begin
          slot = (a - 'h8000) >> 13;
          if (slot < 2) bank = prg_bank[slot];
          else bank = prg_span() - 4 + slot;
          m.region = REGION_PRG_ROM;
          m.local_addr = 17'(bank * 8192 + (a & 'h1FFF));
        end
      end else if (a < 'hA000 && a >= 'h8000) begin
        if (addr[0] == 1'b0) begin
          bank_sel = data[2:0];
        end else begin
          case (bank_sel)
            BSEL_CHR2K_0: set_chr_pair(0, data & 'h3E);
            BSEL_CHR2K_1: set_chr_pair(2, data & 'h3E);
            BSEL_PRG_0:   prg_bank[0] = 4'((data & 'h0F) % prg_span());
            BSEL_PRG_1:   prg_bank[1] = 4'((data & 'h0F) % prg_span());
            default:      chr_bank[bank_sel + 2] = 7'((data & 'h3F) % chr_span());
          endcase
        end
      end
    end else begin
      wr = (act == ACT_PPU_WR);
      if (pa < 'h2000) begin
        if (!wr) begin
          m.region = REGION_CHR_ROM;
          m.local_addr = 17'(chr_bank[(pa >> 10) & 7] * 1024 + (pa & 'h3FF));
        end
      end else begin
        m.region = REGION_NAMETAB;
        m.strobe = wr;
        case (mirror_reg)
          MIR_VERT:  m.local_addr = 17'(pa & 'h7FF);
          MIR_FOUR:  m.local_addr = 17'(pa & 'hFFF);
          MIR_SCR_A: m.local_addr = 17'(pa & 'h3FF);
          MIR_SCR_B: m.local_addr = 17'('h400 | (pa & 'h3FF));
          default:   m.local_addr = 17'(((pa & 'h800) >> 1) | (pa & 'h3FF));
        endcase
      end
    end
    return m;
  endfunction

  function automatic int pick_idle();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_access(action_e act, logic [15:0] addr, logic [7:0] data);
    bus_item_t it;
    it.act = act;
    it.addr = addr;
    it.data = data;
    bus_items.push_back(it);
    sent_total++;
  endfunction

  function automatic void queue_random_access();
    int          r;
    logic [15:0] a;
    r = $urandom_range(0, 99);
    a = 16'($urandom);
    if (r < 22) begin
      // bank select then bank data
      a[15:13] = 3'b100;
      a[0] = 1'b0;
      queue_access(ACT_CPU_WR, a, 8'($urandom));
      a = 16'($urandom);
      a[15:13] = 3'b100;
      a[0] = 1'b1;
      queue_access(ACT_CPU_WR, a, 8'($urandom));
    end else if (r < 42) begin
      a[13] = 1'b0;
      queue_access(ACT_PPU_RD, a, 8'($urandom));
    end else if (r < 57) begin
      a[15] = 1'b1;
      queue_access(ACT_CPU_RD, a, 8'($urandom));
    end else if (r < 70) begin
      a[13] = 1'b1;
      queue_access($urandom_range(0, 1) ? ACT_PPU_WR : ACT_PPU_RD, a, 8'($urandom));
    end else begin
      queue_access(action_e'($urandom_range(0, 3)), a, 8'($urandom));
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, int value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PDATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PRG_CNT: begin
        prg_cnt_reg = value & 'h1F;
        reload_banks();
      end
      REG_CHR_CNT: begin
        chr_cnt_reg = value & 'h7F;
        reload_banks();
      end
      default: mirror_reg = 3'(value);
    endcase
    // bank reload after a count write holds the block busy
    repeat (12) @(negedge clk_i);
  endtask

  task automatic drain();
    while (done_total != sent_total) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  // item driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap = 0;
      item_taken = 1'b0;
    end else if (!in_valid || item_taken) begin
      item_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (bus_items.size() > 0) begin
        nxt = bus_items.pop_front();
        act_r <= nxt.act;
        addr_r <= nxt.addr;
        data_r <= nxt.data;
        in_valid <= 1'b1;
        in_gap = pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_idle();
      out_stall <= 1'b0;
    end
  end

  // stretches without any idling
  always @(posedge clk_i) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // result check and item capture
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_maps.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: region %0d local %0h strobe %0d data %0h",
                   region_o, local_address_o, write_strobe_o, pass_data_o);
        mismatches++;
      end else begin
        got = expected_maps.pop_front();
        if (region_o !== got.region || local_address_o !== got.local_addr ||
            write_strobe_o !== got.strobe || pass_data_o !== got.data) begin
          if (mismatches < 10)
            $display("mismatch: exp region %0d local %0h strobe %0d data %0h, got %0d %0h %0d %0h",
                     got.region, got.local_addr, got.strobe, got.data,
                     region_o, local_address_o, write_strobe_o, pass_data_o);
          mismatches++;
        end
        done_total++;
      end
    end
    if (rst_ni && in_valid && !in_stall_o) begin
      expected_maps.push_back(map_access(action_e'(act_r), addr_r, data_r));
      item_taken = 1'b1;
    end
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int prg_set [8] = '{2, 16, 0, 31, 1, 17, 5, 9};
    int chr_set [8] = '{1, 64, 0, 127, 8, 3, 63, 20};
    prg_cnt_reg = 16;
    chr_cnt_reg = 64;
    mirror_reg = MIR_HORIZ;
    bank_sel = '0;
    reload_banks();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // directed accesses under reset settings
    queue_access(ACT_CPU_RD, 16'h0000, 8'h00);
    queue_access(ACT_CPU_RD, 16'h1FFF, 8'hFF);
    queue_access(ACT_CPU_WR, 16'h07FF, 8'hFF);
    queue_access(ACT_CPU_RD, 16'h2000, 8'h5A);
    queue_access(ACT_CPU_WR, 16'h3FFF, 8'hA5);
    queue_access(ACT_CPU_RD, 16'h4000, 8'h01);
    queue_access(ACT_CPU_WR, 16'h401F, 8'h80);
    queue_access(ACT_CPU_RD, 16'h4020, 8'h33);
    queue_access(ACT_CPU_RD, 16'h7FFF, 8'hCC);
    queue_access(ACT_CPU_WR, 16'h5000, 8'h77);
    queue_access(ACT_CPU_RD, 16'h8000, 8'h00);
    queue_access(ACT_CPU_RD, 16'hA000, 8'h00);
    queue_access(ACT_CPU_RD, 16'hC000, 8'h00);
    queue_access(ACT_CPU_RD, 16'hFFFF, 8'h00);
    queue_access(ACT_CPU_WR, 16'hA001, 8'hFF);
    queue_access(ACT_CPU_WR, 16'hFFFF, 8'hFF);
    queue_access(ACT_CPU_WR, 16'h8000, 8'h00);
    queue_access(ACT_CPU_WR, 16'h8001, 8'hFF);
    queue_access(ACT_CPU_WR, 16'h9FFE, 8'hFB);
    queue_access(ACT_CPU_WR, 16'h9FFF, 8'hFF);
    queue_access(ACT_CPU_WR, 16'h8000, 8'h07);
    queue_access(ACT_CPU_WR, 16'h8001, 8'h0F);
    queue_access(ACT_CPU_RD, 16'hBFFF, 8'h00);
    queue_access(ACT_PPU_RD, 16'h0000, 8'h00);
    queue_access(ACT_PPU_RD, 16'h1FFF, 8'h00);
    queue_access(ACT_PPU_WR, 16'h0400, 8'h11);
    queue_access(ACT_PPU_WR, 16'h2C00, 8'h22);
    queue_access(ACT_PPU_RD, 16'hFFFF, 8'h00);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p >= 6) begin
        prg_set[p] = $urandom_range(0, 31);
        chr_set[p] = $urandom_range(0, 127);
      end
      write_reg(REG_PRG_CNT, prg_set[p]);
      write_reg(REG_CHR_CNT, chr_set[p]);
      write_reg(REG_MIRROR, p);
      for (int n = 0; n < 90; n++) queue_random_access();
      drain();
    end

    if (mismatches == 0 && expected_maps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
